// File: rtl/bpcr_pkg.sv
// Package for the buffer pool clock replacer: operation and status codes,
// controller states and the command and status structs. No dependencies.
package bpcr_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PIN   = 2'd0,
    OP_UNPIN = 2'd1,
    OP_MARK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_RES    = 2'd1,
    ST_ALL_PINNED = 2'd2,
    ST_UNUSED     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_SWEEP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic apply;
    logic fill;
    logic sweep_init;
    logic sweep_step;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic is_pin;
    logic fill_ok;
    logic victim;
    logic sweep_last;
  } dp_stat_t;

endpackage

// File: rtl/buffer_pool_clock_replacer.sv
// Top level of the buffer pool clock replacer: controller plus datapath.
// Depends on bpcr_pkg, bpcr_ctrl and bpcr_datapath.
//
//   channel  handshake          payload
//   in       start / busy       in_operation, in_page_id
//   out      out_valid strobe   out_status ... out_writeback_needed
//   cfg      cfg_we             cfg_data (frames_in_use)
//
// A hit, a fill or an unpin, mark or flush goes from start through MATCH and
// DECIDE to the out_valid strobe in RESP; a miss that sweeps adds a SWEEP step
// per position the clock hand visits, at most 2*NUM_FRAMES, one frame a cycle.
// busy is low only in S_IDLE, so it is high through the strobe cycle.
// Reset is synchronous; all frames are empty afterwards, no clearing pass.
// Results show for one cycle only; the receiver cannot stall them.
module buffer_pool_clock_replacer #(
  parameter int NUM_FRAMES   = 16,
  parameter int PAGE_ID_BITS = 32,
  parameter int PIN_BITS     = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_operation,
  input  logic [PAGE_ID_BITS-1:0]           in_page_id,
  input  logic                              cfg_we,
  input  logic [bpcr_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [$clog2(NUM_FRAMES)-1:0]     out_frame_index,
  output logic                              out_hit,
  output logic                              out_load_needed,
  output logic                              out_evict_valid,
  output logic [PAGE_ID_BITS-1:0]           out_evicted_page_id,
  output logic                              out_writeback_needed
);
  import bpcr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  bpcr_datapath #(
    .NUM_FRAMES   (NUM_FRAMES),
    .PAGE_ID_BITS (PAGE_ID_BITS),
    .PIN_BITS     (PIN_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_operation         (in_operation),
    .in_page_id           (in_page_id),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .out_status           (out_status),
    .out_frame_index      (out_frame_index),
    .out_hit              (out_hit),
    .out_load_needed      (out_load_needed),
    .out_evict_valid      (out_evict_valid),
    .out_evicted_page_id  (out_evicted_page_id),
    .out_writeback_needed (out_writeback_needed)
  );

endmodule

// File: rtl/bpcr_datapath.sv
// Datapath of the buffer pool clock replacer: frame table, tag match,
// clock hand, sweep counter and result registers. Depends on bpcr_pkg.
module bpcr_datapath #(
  parameter int NUM_FRAMES   = 16,
  parameter int PAGE_ID_BITS = 32,
  parameter int PIN_BITS     = 8,
  parameter int IDX_W        = $clog2(NUM_FRAMES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bpcr_pkg::dp_cmd_t        cmd,
  output bpcr_pkg::dp_stat_t       stat,
  input  logic [1:0]               in_operation,
  input  logic [PAGE_ID_BITS-1:0]  in_page_id,
  input  logic                     cfg_we,
  input  logic [bpcr_pkg::CFG_W-1:0] cfg_data,
  output logic [1:0]               out_status,
  output logic [IDX_W-1:0]         out_frame_index,
  output logic                     out_hit,
  output logic                     out_load_needed,
  output logic                     out_evict_valid,
  output logic [PAGE_ID_BITS-1:0]  out_evicted_page_id,
  output logic                     out_writeback_needed
);
  import bpcr_pkg::*;

  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int STEP_W = $clog2(2 * NUM_FRAMES);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic [NUM_FRAMES-1:0]   valid_r, ref_r, dirty_r;
  logic [PIN_BITS-1:0]     pin_r [NUM_FRAMES];
  logic [PAGE_ID_BITS-1:0] page_r [NUM_FRAMES];
  logic [IDX_W-1:0]        hand_r;
  logic [CNT_W-1:0]        filled_r;
  logic [CFG_W-1:0]        limit_cfg_r;
  logic [STEP_W-1:0]       step_r;
  op_t                     op_r;
  logic [PAGE_ID_BITS-1:0] req_page_r;
  logic                    found_r;
  logic [IDX_W-1:0]        match_idx_r;

  logic [1:0]              status_r;
  logic [IDX_W-1:0]        findex_r;
  logic                    hit_r, load_r, ev_r, wb_r;
  logic [PAGE_ID_BITS-1:0] evpage_r;

  logic [NUM_FRAMES-1:0]   hit_vec;
  logic [IDX_W-1:0]        hit_idx;
  logic [CMP_W-1:0]        lim;
  logic                    cand;
  logic [IDX_W-1:0]        hand_nxt;
  logic [IDX_W-1:0]        wr_idx;
  logic                    install;

  // Page ids are unique among valid frames, so the matching index is an OR.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      hit_vec[i] = valid_r[i] && (page_r[i] == req_page_r);
      if (hit_vec[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  always_comb begin
    lim = (limit_cfg_r == '0) ? CMP_W'(1) : CMP_W'(limit_cfg_r);
    if (lim > CMP_W'(NUM_FRAMES)) lim = CMP_W'(NUM_FRAMES);
  end

  assign cand     = valid_r[hand_r] && (pin_r[hand_r] == '0);
  assign hand_nxt = (hand_r == IDX_W'(NUM_FRAMES - 1)) ? '0 : hand_r + 1'b1;
  assign install  = cmd.fill || (cmd.sweep_step && cand && !ref_r[hand_r]);
  assign wr_idx   = cmd.fill ? IDX_W'(filled_r) : hand_r;

  assign stat.found      = found_r;
  assign stat.is_pin     = (op_r == OP_PIN);
  assign stat.fill_ok    = CMP_W'(filled_r) < lim;
  assign stat.victim     = cand && !ref_r[hand_r];
  assign stat.sweep_last = (step_r == STEP_W'(2 * NUM_FRAMES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= FRAMES_IN_USE_RESET;
    end else if (cfg_we) begin
      limit_cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_t'(in_operation);
      req_page_r <= in_page_id;
    end
    if (cmd.match) begin
      found_r     <= |hit_vec;
      match_idx_r <= hit_idx;
    end
    if (install) page_r[wr_idx] <= req_page_r;
    if (cmd.sweep_init) step_r <= '0;
    else if (cmd.sweep_step) step_r <= step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ref_r    <= '0;
      dirty_r  <= '0;
      hand_r   <= '0;
      filled_r <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) pin_r[i] <= '0;
    end else begin
      if (cmd.apply && found_r) begin
        unique case (op_r)
          OP_PIN: begin
            if (pin_r[match_idx_r] != PIN_MAX) pin_r[match_idx_r] <= pin_r[match_idx_r] + 1'b1;
            ref_r[match_idx_r] <= 1'b1;
          end
          OP_UNPIN: begin
            if (pin_r[match_idx_r] != '0) pin_r[match_idx_r] <= pin_r[match_idx_r] - 1'b1;
          end
          OP_MARK:  dirty_r[match_idx_r] <= 1'b1;
          OP_FLUSH: dirty_r[match_idx_r] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.fill) filled_r <= filled_r + 1'b1;
      if (cmd.sweep_step) begin
        hand_r <= hand_nxt;
        if (cand && ref_r[hand_r]) ref_r[hand_r] <= 1'b0;
      end
      if (install) begin
        valid_r[wr_idx] <= 1'b1;
        pin_r[wr_idx]   <= PIN_BITS'(1);
        ref_r[wr_idx]   <= 1'b1;
        dirty_r[wr_idx] <= 1'b0;
      end
    end
  end

  // Result registers; cleared when a transaction is captured.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r <= ST_OK;
      findex_r <= '0;
      hit_r    <= 1'b0;
      load_r   <= 1'b0;
      ev_r     <= 1'b0;
      wb_r     <= 1'b0;
      evpage_r <= '0;
    end else if (cmd.apply) begin
      if (!found_r) begin
        status_r <= ST_NOT_RES;
      end else begin
        findex_r <= match_idx_r;
        hit_r    <= (op_r == OP_PIN);
        wb_r     <= (op_r == OP_FLUSH) && dirty_r[match_idx_r];
      end
    end else if (cmd.fill) begin
      findex_r <= IDX_W'(filled_r);
      load_r   <= 1'b1;
    end else if (cmd.sweep_step) begin
      if (stat.victim) begin
        findex_r <= hand_r;
        load_r   <= 1'b1;
        ev_r     <= 1'b1;
        evpage_r <= page_r[hand_r];
        wb_r     <= dirty_r[hand_r];
      end else if (stat.sweep_last) begin
        status_r <= ST_ALL_PINNED;
      end
    end
  end

  assign out_status           = status_r;
  assign out_frame_index      = findex_r;
  assign out_hit              = hit_r;
  assign out_load_needed      = load_r;
  assign out_evict_valid      = ev_r;
  assign out_evicted_page_id  = evpage_r;
  assign out_writeback_needed = wb_r;

endmodule

// File: rtl/bpcr_ctrl.sv
// Controller of the buffer pool clock replacer: sequences capture, match,
// decision and clock sweep. Depends on bpcr_pkg.
module bpcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output bpcr_pkg::dp_cmd_t  cmd,
  input  bpcr_pkg::dp_stat_t stat
);
  import bpcr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_MATCH;
      S_MATCH:  state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!stat.is_pin || stat.found || stat.fill_ok) state_nxt = S_RESP;
        else state_nxt = S_SWEEP;
      end
      S_SWEEP:  if (stat.victim || stat.sweep_last) state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_MATCH:  cmd.match = 1'b1;
      S_DECIDE: begin
        if (!stat.is_pin || stat.found) cmd.apply = 1'b1;
        else if (stat.fill_ok) cmd.fill = 1'b1;
        else cmd.sweep_init = 1'b1;
      end
      S_SWEEP:  cmd.sweep_step = 1'b1;
      S_RESP:   out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

// File: rtl/bpcr_checker.sv
// Port checker for the buffer pool clock replacer, bound to the top level.
// Depends on bpcr_pkg and buffer_pool_clock_replacer.
module bpcr_checker #(
  parameter int IDX_W = 4
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [1:0]       out_status,
  input logic [IDX_W-1:0] out_frame_index,
  input logic             out_hit,
  input logic             out_load_needed,
  input logic             out_evict_valid
);
  import bpcr_pkg::*;

  // An accepted transaction makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start accepted but busy not raised");

  // Every result ends its transaction.
  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy stays high after a result");

  // A result only appears while a transaction is in flight.
  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without a transaction");

  // Error results carry no frame information.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_RES || out_status == ST_ALL_PINNED) |->
      (out_frame_index == '0) && !out_hit && !out_load_needed && !out_evict_valid)
    else $error("error result carries frame fields");

  // An eviction always comes with a load into the same frame.
  a_evict_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evict_valid |-> out_load_needed && !out_hit)
    else $error("eviction without a load");

endmodule

bind buffer_pool_clock_replacer bpcr_checker #(
  .IDX_W ($clog2(NUM_FRAMES))
) u_bpcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_frame_index (out_frame_index),
  .out_hit         (out_hit),
  .out_load_needed (out_load_needed),
  .out_evict_valid (out_evict_valid)
);
